FILE: sv/periodic_flag_timer_bank_assert.svh
// Assertion macros shared by the timer bank modules.
// The macros expect a signal named clk, and PFTB_ASSERT also rst_n, in the using module.
`ifndef PERIODIC_FLAG_TIMER_BANK_ASSERT_SVH
`define PERIODIC_FLAG_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside of reset.
`define PFTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PFTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PFTB_ASSERT(lbl, prop, msg)
`define PFTB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/pftb_pkg.sv
`default_nettype none

package pftb_pkg;

  // Default number of flag slots.
  localparam int NUM_FLAGS_DEF = 8;

  // Millisecond counter wraps into seconds here.
  localparam int MS_WRAP = 1000;

  // Command codes of an input beat.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_DELAY  = 2'd3
  } cmd_t;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period_ticks;
    logic [2:0]  flag_id;
    logic [15:0] delay_ms;
  } pftb_in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0]  pending_flags;
    logic [3:0]  active_count;
    logic [1:0]  status;
    logic [2:0]  assigned_id;
    logic [9:0]  milliseconds;
    logic [31:0] seconds;
    logic        delay_busy;
  } pftb_out_t;

  // Control broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic        tick;
    logic        create;
    logic [15:0] interval;
  } pftb_ctl_t;

  // Status returned by one cell.
  typedef struct packed {
    logic created;
    logic pending;
    logic pend_nxt;
    logic found;
  } pftb_cell_st_t;

endpackage

`default_nettype wire

FILE: sv/pftb_cell.sv
`default_nettype none

// One flag slot: period, countdown and pending mark. The created bit is
// handed to the next cell so that a create lands in the first free slot.
module pftb_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pftb_pkg::pftb_ctl_t    ctl,
  input  wire logic                   ack_hit,
  input  wire logic                   prev_created,
  output pftb_pkg::pftb_cell_st_t     st
);
  import pftb_pkg::*;

  logic        created_r, created_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_dec;
  logic        take;

  // This slot takes a create when its predecessor is in use and it is not.
  assign take      = ctl.create && prev_created && !created_r;
  assign count_dec = count_r - 16'd1;

  // Next state of the slot.
  always_comb begin
    created_nxt = created_r;
    pending_nxt = pending_r;
    period_nxt  = period_r;
    count_nxt   = count_r;
    if (take) begin
      created_nxt = 1'b1;
      pending_nxt = 1'b0;
      period_nxt  = ctl.interval;
      count_nxt   = ctl.interval;
    end else if (ctl.tick && created_r) begin
      if (count_dec == 16'd0) begin
        pending_nxt = 1'b1;
        count_nxt   = period_r;
      end else begin
        count_nxt = count_dec;
      end
    end else if (ack_hit && created_r) begin
      pending_nxt = 1'b0;
    end
  end

  // Control bits reset; the period and countdown are written on create.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r <= 1'b0;
      pending_r <= 1'b0;
    end else begin
      created_r <= created_nxt;
      pending_r <= pending_nxt;
    end
    period_r <= period_nxt;
    count_r  <= count_nxt;
  end

  assign st.created  = created_r;
  assign st.pending  = pending_r;
  assign st.pend_nxt = pending_nxt;
  assign st.found    = ack_hit && created_r;

endmodule

`default_nettype wire

FILE: sv/periodic_flag_timer_bank.sv
// Periodic flag timer bank with a millisecond mission clock.
//
// Input channel (in_valid, in_stall, in_data) carries one command per beat:
// a millisecond tick, a flag create, a flag acknowledge or a delay start.
// Result channel (out_valid, out_stall, out_data) returns exactly one beat
// per command, showing the pending flags, slot count, status, assigned
// slot, mission time and delay state after that command.
//
// The result is registered at the edge that accepts the command. Throughput
// is one command per cycle while no result is held, set by the row of slot
// cells that all update in the same cycle as the clock and delay counters.
// While a result waits under out_stall, in_stall is raised and the result
// holds; the next command is taken in the cycle the result leaves.
//
// Synchronous reset (rst_n low) clears the clock, the delay, the slot count
// and all pending marks. A slot's period and countdown are loaded on create.
`default_nettype none

`include "periodic_flag_timer_bank_assert.svh"

module periodic_flag_timer_bank #(
  parameter int NUM_FLAGS = pftb_pkg::NUM_FLAGS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pftb_pkg::pftb_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pftb_pkg::pftb_out_t      out_data
);
  import pftb_pkg::*;

  localparam int CW = $clog2(NUM_FLAGS + 1);

  logic                  accept;
  logic                  is_tick, is_create, is_ack, is_delay;
  pftb_ctl_t             ctl;
  logic [NUM_FLAGS-1:0]  ack_hit;
  logic [NUM_FLAGS:0]    created_chain;
  pftb_cell_st_t         cell_st [NUM_FLAGS];
  logic [NUM_FLAGS-1:0]  created_vec, pend_vec, pend_nxt_vec, found_vec;
  logic [63:0]           pend_ext;
  logic [6:0]            cnt_ext, cnt_nxt_ext;

  logic [CW-1:0]         count_r, count_nxt;
  logic [9:0]            ms_r, ms_nxt;
  logic [31:0]           sec_r, sec_nxt;
  logic [15:0]           dly_left_r, dly_left_nxt;
  logic                  dly_run_r, dly_run_nxt;
  logic                  full;
  logic                  out_valid_r, out_valid_nxt;
  pftb_out_t             out_data_r, out_data_nxt;

  // Handshake: a result under stall blocks the next beat.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Command decode.
  assign is_tick   = accept && (in_data.cmd == CMD_TICK);
  assign is_create = accept && (in_data.cmd == CMD_CREATE);
  assign is_ack    = accept && (in_data.cmd == CMD_ACK);
  assign is_delay  = accept && (in_data.cmd == CMD_DELAY);
  assign full      = (count_r == CW'(NUM_FLAGS));

  assign ctl.tick     = is_tick;
  assign ctl.create   = is_create;
  assign ctl.interval = in_data.period_ticks;

  // Row of slot cells; each hands its created bit to the next one.
  assign created_chain[0] = 1'b1;
  for (genvar g = 0; g < NUM_FLAGS; g++) begin : g_cell
    assign ack_hit[g] = is_ack && (7'(g) == {4'b0000, in_data.flag_id});

    pftb_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .ack_hit      (ack_hit[g]),
      .prev_created (created_chain[g]),
      .st           (cell_st[g])
    );

    assign created_chain[g+1] = cell_st[g].created;
    assign created_vec[g]     = cell_st[g].created;
    assign pend_vec[g]        = cell_st[g].pending;
    assign pend_nxt_vec[g]    = cell_st[g].pend_nxt;
    assign found_vec[g]       = cell_st[g].found;
  end

  // Mission clock, delay and slot count.
  always_comb begin
    ms_nxt       = ms_r;
    sec_nxt      = sec_r;
    dly_left_nxt = dly_left_r;
    dly_run_nxt  = dly_run_r;
    count_nxt    = count_r;
    if (is_tick) begin
      if (ms_r == 10'(MS_WRAP - 1)) begin
        ms_nxt  = 10'd0;
        sec_nxt = sec_r + 32'd1;
      end else begin
        ms_nxt = ms_r + 10'd1;
      end
      if (dly_run_r) begin
        dly_left_nxt = dly_left_r - 16'd1;
        if (dly_left_nxt == 16'd0) begin
          dly_run_nxt = 1'b0;
        end
      end
    end
    if (is_delay) begin
      dly_left_nxt = in_data.delay_ms;
      dly_run_nxt  = 1'b1;
    end
    if (is_create && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // Result beat built from the state after the command.
  assign pend_ext    = 64'(pend_nxt_vec);
  assign cnt_ext     = 7'(count_r);
  assign cnt_nxt_ext = 7'(count_nxt);

  always_comb begin
    out_data_nxt               = out_data_r;
    out_valid_nxt              = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.pending_flags = pend_ext[7:0];
      out_data_nxt.active_count  = cnt_nxt_ext[3:0];
      out_data_nxt.status        = ST_OK;
      out_data_nxt.assigned_id   = 3'd0;
      out_data_nxt.milliseconds  = ms_nxt;
      out_data_nxt.seconds       = sec_nxt;
      out_data_nxt.delay_busy    = dly_run_nxt;
      if (is_create) begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          out_data_nxt.assigned_id = cnt_ext[2:0];
        end
      end
      if (is_ack && (found_vec == '0)) begin
        out_data_nxt.status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ms_r        <= 10'd0;
      sec_r       <= 32'd0;
      dly_left_r  <= 16'd0;
      dly_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ms_r        <= ms_nxt;
      sec_r       <= sec_nxt;
      dly_left_r  <= dly_left_nxt;
      dly_run_r   <= dly_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The millisecond count never reaches the wrap value.
  `PFTB_ASSERT(a_ms_range, ms_r < 10'(MS_WRAP), "millisecond count out of range")
  // The slot count agrees with the cells that are in use.
  `PFTB_ASSERT(a_count_cells, $countones(created_vec) == int'(count_r),
    "slot count disagrees with created cells")
  // Only created slots can be pending.
  `PFTB_ASSERT(a_pend_created, (pend_vec & ~created_vec) == '0,
    "pending mark on an unused slot")
  // An idle delay has run down to zero.
  `PFTB_ASSERT(a_delay_idle, !dly_run_r |-> (dly_left_r == 16'd0),
    "idle delay with time left")
  // A stalled result stays valid.
  `PFTB_ASSERT(a_result_held, out_valid_r && out_stall |=> out_valid_r,
    "stalled result dropped")

endmodule

`default_nettype wire
